[rtl/vpmr_pkg.sv]
package vpmr_pkg;

   localparam int VPMR_PALETTE_WORDS = 512;
   localparam int PAL_IDX_W          = 9;

   // Bus access kinds as they arrive on the request channel
   localparam logic [2:0] KIND_BREAD  = 3'd0;
   localparam logic [2:0] KIND_WREAD  = 3'd1;
   localparam logic [2:0] KIND_BWRITE = 3'd2;
   localparam logic [2:0] KIND_WWRITE = 3'd3;
   localparam logic [2:0] KIND_PEEK   = 3'd4;

   // Window map
   localparam logic [11:0] VR0_BASE      = 12'h400;
   localparam logic [11:0] VR1_BASE      = 12'h500;
   localparam logic [11:0] VR2_BASE      = 12'h600;
   localparam logic [11:0] UNMAPPED_BASE = 12'h700;

   localparam logic [7:0] VR1H_MASK    = 8'h3f;
   localparam logic [7:0] SHADOW_RESET = 8'hff;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_BREAD,
      OP_WREAD,
      OP_BWRITE,
      OP_WWRITE
   } vpmr_op_type;

   typedef enum logic [2:0] {
      RGN_NONE,
      RGN_PAL,
      RGN_VR0,
      RGN_VR1,
      RGN_VR2
   } vpmr_region_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [11:0] offset;
      logic [15:0] write_data;
   } vpmr_req_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        palette_wait;
      logic        palette_changed;
      logic [8:0]  palette_index;
      logic        mode_changed;
      logic [2:0]  vr0_value;
      logic [13:0] vr1_value;
      logic [15:0] vr2_value;
   } vpmr_rsp_type;

   // Decoded access handed from the front to the back
   typedef struct packed {
      vpmr_op_type            op;
      vpmr_region_type        region;
      logic                   peek;
      logic                   odd;
      logic [PAL_IDX_W-1:0]   index;
      logic [15:0]            write_data;
   } vpmr_cmd_type;

endpackage

[rtl/vpmr_ram.sv]
module vpmr_ram
   #(
      parameter int WIDTH = 16,
      parameter int DEPTH = 512
   )
   (
      input  logic                     clock,
      input  logic                     wr_en,
      input  logic [$clog2(DEPTH)-1:0] wr_addr,
      input  logic [WIDTH-1:0]         wr_data,
      input  logic [$clog2(DEPTH)-1:0] rd_addr,
      output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/vpmr_front.sv]
module vpmr_front
   import vpmr_pkg::*;
   #(
      parameter int PALETTE_WORDS = VPMR_PALETTE_WORDS
   )
   (
      input  logic         req_valid,
      output logic         req_ready,
      input  vpmr_req_type req_item,
      input  logic         queue_full,
      input  logic         clearing,
      output logic         push,
      output vpmr_cmd_type push_cmd
   );

   // Reduce a word index modulo the palette size by binary compare/subtract
   function automatic logic [PAL_IDX_W-1:0] wrap_index(input logic [PAL_IDX_W-1:0] w);
      logic [15:0] v;
      v = 16'(w);
      for (int k = 5; k >= 0; k--) begin
         if (v >= 16'(PALETTE_WORDS << k)) begin
            v = v - 16'(PALETTE_WORDS << k);
         end
      end
      return v[PAL_IDX_W-1:0];
   endfunction

   vpmr_region_type region;

   always_comb begin
      if (req_item.offset < VR0_BASE) begin
         region = RGN_PAL;
      end else if (req_item.offset < VR1_BASE) begin
         region = RGN_VR0;
      end else if (req_item.offset < VR2_BASE) begin
         region = RGN_VR1;
      end else if (req_item.offset < UNMAPPED_BASE) begin
         region = RGN_VR2;
      end else begin
         region = RGN_NONE;
      end
   end

   always_comb begin
      push_cmd.region     = region;
      push_cmd.peek       = 1'b0;
      push_cmd.odd        = req_item.offset[0];
      push_cmd.index      = wrap_index(req_item.offset[PAL_IDX_W:1]);
      push_cmd.write_data = req_item.write_data;
      case (req_item.kind)
         KIND_BREAD: begin
            push_cmd.op = OP_BREAD;
         end
         KIND_WREAD: begin
            push_cmd.op = OP_WREAD;
         end
         KIND_BWRITE: begin
            push_cmd.op = OP_BWRITE;
         end
         KIND_WWRITE: begin
            push_cmd.op = OP_WWRITE;
         end
         KIND_PEEK: begin
            push_cmd.op   = OP_BREAD;
            push_cmd.peek = 1'b1;
         end
         default: begin
            // drop unused kinds to a no-op result
            push_cmd.op     = OP_NONE;
            push_cmd.region = RGN_NONE;
         end
      endcase
   end

   assign req_ready = !queue_full && !clearing;
   assign push      = req_valid && req_ready;

endmodule

[rtl/vpmr_queue.sv]
module vpmr_queue
   import vpmr_pkg::*;
   (
      input  logic         clock,
      input  logic         reset,
      input  logic         push,
      input  vpmr_cmd_type push_cmd,
      input  logic         pop,
      output logic         full,
      output logic         empty,
      output vpmr_cmd_type head_cmd
   );

   vpmr_cmd_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/vpmr_back.sv]
module vpmr_back
   import vpmr_pkg::*;
   #(
      parameter int PALETTE_WORDS = VPMR_PALETTE_WORDS
   )
   (
      input  logic         clock,
      input  logic         reset,
      input  logic         q_empty,
      input  vpmr_cmd_type q_head,
      output logic         q_pop,
      output logic         clearing,
      output logic         rsp_valid,
      input  logic         rsp_ready,
      output vpmr_rsp_type rsp_item
   );

   localparam int IDX_W = $clog2(PALETTE_WORDS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_WORDS - 1);

   localparam int SH_VR1H = 0;
   localparam int SH_VR1L = 1;
   localparam int SH_VR2H = 2;
   localparam int SH_VR2L = 3;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type    state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   vpmr_cmd_type cur_ff, cur_in;
   logic         rsp_valid_ff, rsp_valid_in;
   vpmr_rsp_type rsp_ff, rsp_in;

   logic         size_ff, size_in;
   logic [1:0]   cmode_ff, cmode_in;
   logic [5:0]   prio_hi_ff, prio_hi_in;
   logic [7:0]   prio_lo_ff, prio_lo_in;
   logic [15:0]  flags_ff, flags_in;
   logic [7:0]   shadow_ff [4];
   logic [7:0]   shadow_in [4];

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [15:0]      ram_wdata;
   logic [15:0]      ram_rdata;

   logic [15:0] old_word;
   logic [15:0] new_word;
   logic [15:0] reg_word;
   logic        is_word;
   logic        is_write;
   logic        lo_sel;
   logic        hi_sel;
   logic [7:0]  lo_byte;
   logic [7:0]  hi_byte;
   logic [7:0]  vr1h_byte;

   vpmr_ram #(
      .WIDTH(16),
      .DEPTH(PALETTE_WORDS)
   ) u_palette (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(q_head.index[IDX_W-1:0]),
      .rd_data(ram_rdata)
   );

   assign q_pop     = (state_ff == S_IDLE) && !q_empty && (!rsp_valid_ff || rsp_ready);
   assign clearing  = (state_ff == S_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      old_word  = ram_rdata;
      is_word   = (cur_ff.op == OP_WWRITE);
      is_write  = cur_ff.op inside {OP_BWRITE, OP_WWRITE};
      lo_sel    = is_word || cur_ff.odd;
      hi_sel    = is_word || !cur_ff.odd;
      lo_byte   = cur_ff.write_data[7:0];
      hi_byte   = is_word ? cur_ff.write_data[15:8] : cur_ff.write_data[7:0];
      vr1h_byte = hi_byte & VR1H_MASK;
      new_word  = old_word;

      case (cur_ff.region)
         RGN_VR0: reg_word = {13'd0, size_ff, cmode_ff};
         RGN_VR1: reg_word = {2'd0, prio_hi_ff, prio_lo_ff};
         RGN_VR2: reg_word = flags_ff;
         default: reg_word = 16'd0;
      endcase

      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      size_in      = size_ff;
      cmode_in     = cmode_ff;
      prio_hi_in   = prio_hi_ff;
      prio_lo_in   = prio_lo_ff;
      flags_in     = flags_ff;
      shadow_in    = shadow_ff;
      ram_we       = 1'b0;
      ram_waddr    = cur_ff.index[IDX_W-1:0];
      ram_wdata    = new_word;

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = 16'd0;
            clr_in    = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_pop) begin
               cur_in   = q_head;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_in       = '0;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            case (cur_ff.region)
               RGN_PAL: begin
                  rsp_in.palette_index = cur_ff.index;
                  rsp_in.palette_wait  = !cur_ff.peek;
                  case (cur_ff.op)
                     OP_WREAD:  rsp_in.read_data = old_word;
                     OP_BREAD:  rsp_in.read_data = {8'd0, cur_ff.odd ? old_word[7:0]
                                                                    : old_word[15:8]};
                     OP_WWRITE: new_word = cur_ff.write_data;
                     OP_BWRITE: new_word = cur_ff.odd ? {old_word[15:8], lo_byte}
                                                      : {lo_byte, old_word[7:0]};
                     default:   new_word = old_word;
                  endcase
                  ram_wdata = new_word;
                  if (is_write && (new_word != old_word)) begin
                     ram_we                 = 1'b1;
                     rsp_in.palette_changed = 1'b1;
                  end
               end
               RGN_VR0, RGN_VR1, RGN_VR2: begin
                  if (cur_ff.op == OP_WREAD) begin
                     rsp_in.read_data = reg_word;
                  end else if (cur_ff.op == OP_BREAD) begin
                     rsp_in.read_data = {8'd0, cur_ff.odd ? reg_word[7:0] : reg_word[15:8]};
                  end else if (is_write) begin
                     if (cur_ff.region == RGN_VR0) begin
                        if (lo_sel) begin
                           size_in  = lo_byte[2];
                           cmode_in = lo_byte[1:0];
                           rsp_in.mode_changed = (lo_byte[2] != size_ff) ||
                                                 (lo_byte[1:0] != cmode_ff);
                        end
                     end else if (cur_ff.region == RGN_VR1) begin
                        if (lo_sel && (lo_byte != shadow_ff[SH_VR1L])) begin
                           shadow_in[SH_VR1L]  = lo_byte;
                           prio_lo_in          = lo_byte;
                           rsp_in.mode_changed = 1'b1;
                        end
                        if (hi_sel && (vr1h_byte != shadow_ff[SH_VR1H])) begin
                           shadow_in[SH_VR1H]  = vr1h_byte;
                           prio_hi_in          = vr1h_byte[5:0];
                           rsp_in.mode_changed = 1'b1;
                        end
                     end else begin
                        if (lo_sel && (lo_byte != shadow_ff[SH_VR2L])) begin
                           shadow_in[SH_VR2L]  = lo_byte;
                           flags_in[7:0]       = lo_byte;
                           rsp_in.mode_changed = 1'b1;
                        end
                        if (hi_sel && (hi_byte != shadow_ff[SH_VR2H])) begin
                           shadow_in[SH_VR2H]  = hi_byte;
                           flags_in[15:8]      = hi_byte;
                           rsp_in.mode_changed = 1'b1;
                        end
                     end
                  end
               end
               default: begin
                  rsp_in.read_data = 16'd0;
               end
            endcase
            rsp_in.vr0_value = {size_in, cmode_in};
            rsp_in.vr1_value = {prio_hi_in, prio_lo_in};
            rsp_in.vr2_value = flags_in;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         size_ff      <= 1'b0;
         cmode_ff     <= 2'd0;
         prio_hi_ff   <= 6'd0;
         prio_lo_ff   <= 8'd0;
         flags_ff     <= 16'd0;
         for (int i = 0; i < 4; i++) begin
            shadow_ff[i] <= SHADOW_RESET;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         size_ff      <= size_in;
         cmode_ff     <= cmode_in;
         prio_hi_ff   <= prio_hi_in;
         prio_lo_ff   <= prio_lo_in;
         flags_ff     <= flags_in;
         shadow_ff    <= shadow_in;
      end
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

endmodule

[rtl/video_palette_and_mode_registers.sv]
// Channel    Direction  Handshake               Payload
// req_       in         req_valid / req_ready   vpmr_req_type: kind, offset, write_data
// rsp_       out        rsp_valid / rsp_ready   vpmr_rsp_type: read data, flags, VR0..VR2
//
// Execute handles each item in order: it reads the palette word from the palette RAM
// (registered read), then updates it and the mode registers and loads the result
// register. Execute takes no new item until the last one has loaded the result register;
// rsp_valid rises when the result register is loaded.
// After reset a clearing pass writes zero to all PALETTE_WORDS palette entries, one per
// cycle; req_ready stays low until the pass is done.
// A two-entry queue sits between decode and execute, so requests are taken while a result
// waits in the output register; a stalled result holds execute but not decode.
module video_palette_and_mode_registers
   import vpmr_pkg::*;
   #(
      parameter int PALETTE_WORDS = VPMR_PALETTE_WORDS
   )
   (
      input  logic         clock,
      input  logic         reset,
      input  logic         req_valid,
      output logic         req_ready,
      input  vpmr_req_type req_item,
      output logic         rsp_valid,
      input  logic         rsp_ready,
      output vpmr_rsp_type rsp_item
   );

   logic         clearing;
   logic         q_push;
   logic         q_pop;
   logic         q_full;
   logic         q_empty;
   vpmr_cmd_type push_cmd;
   vpmr_cmd_type head_cmd;

   // Decode: classify the access by kind and window region, wrap the palette index
   vpmr_front #(
      .PALETTE_WORDS(PALETTE_WORDS)
   ) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .queue_full(q_full),
      .clearing  (clearing),
      .push      (q_push),
      .push_cmd  (push_cmd)
   );

   // Hold decoded items until execute is free
   vpmr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_cmd(push_cmd),
      .pop     (q_pop),
      .full    (q_full),
      .empty   (q_empty),
      .head_cmd(head_cmd)
   );

   // Execute: palette read-modify-write, mode registers (VR1 and VR2 with shadows), result register
   vpmr_back #(
      .PALETTE_WORDS(PALETTE_WORDS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (head_cmd),
      .q_pop    (q_pop),
      .clearing (clearing),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item)
   );

   // No request taken while the palette is being cleared
   assert property (@(posedge clock) disable iff (reset) clearing |-> !req_ready)
      else $error("request accepted during palette clear");

   // A palette change only comes from a waited write, which reads back zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.palette_changed |->
         rsp_item.palette_wait && (rsp_item.read_data == 16'd0))
      else $error("palette change on a non-write access");

   // A mode change never touches the palette
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.mode_changed |->
         !rsp_item.palette_wait && !rsp_item.palette_changed &&
         (rsp_item.palette_index == 9'd0))
      else $error("mode change reported with palette activity");

   // Execute never pops from an empty queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("pop from empty queue");

endmodule
